>>> sv/smpq_pkg.sv
`default_nettype none
package smpq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int VALUE_W = 32;
	localparam int FILL_W  = 5;

	typedef struct packed {
		logic [VALUE_W-1:0] value_out;
		logic [1:0]         status;
		logic               queue_empty;
		logic [FILL_W-1:0]  fill_count;
	} smpq_result_t;

endpackage
`default_nettype wire

>>> sv/smpq_req_if.sv
`default_nettype none
interface smpq_req_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [31:0] value_in;

	modport source (output valid, output operation, output value_in, input ready);
	modport sink (input valid, input operation, input value_in, output ready);
endinterface
`default_nettype wire

>>> sv/smpq_rsp_if.sv
`default_nettype none
interface smpq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_out;
	logic [1:0]         status;
	logic               queue_empty;
	logic [4:0]         fill_count;

	modport source (output valid, output value_out, output status, output queue_empty,
		output fill_count, input ready);
	modport sink (input valid, input value_out, input status, input queue_empty,
		input fill_count, output ready);
endinterface
`default_nettype wire

>>> sv/sorted_max_priority_queue_unit.sv
// a rejected item goes from accept to the finish state, then into the output register;
//   an insert shifts smaller entries up one by one, a remove shifts the rest down one
// one item in work at a time: the next one is accepted only when the control is back in
//   idle, after the previous result enters the output register
// a finished result waits in the output register while the next item is accepted
// reset: arst_n clears the count and the handshake state; memory contents stay undefined
`default_nettype none
module sorted_max_priority_queue_unit
	import smpq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	smpq_req_if.sink    req,
	smpq_rsp_if.source  rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	logic         done_valid;
	logic         done_ready;
	smpq_result_t done_result;

	smpq_result_t res_q;
	logic         res_valid_q;

	smpq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_WIDTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	smpq_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_op      (req.operation),
		.req_value   (req.value_in),
		.done_valid  (done_valid),
		.done_ready  (done_ready),
		.done_result (done_result),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	// output register
	assign done_ready = !res_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done_valid && done_ready) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) begin
			res_q <= done_result;
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.value_out   = $signed(res_q.value_out);
	assign rsp.status      = res_q.status;
	assign rsp.queue_empty = res_q.queue_empty;
	assign rsp.fill_count  = res_q.fill_count;

endmodule
`default_nettype wire

>>> sv/smpq_ram.sv
`default_nettype none
module smpq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> sv/smpq_ctrl.sv
`default_nettype none
module smpq_ctrl
	import smpq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = 4,
	parameter int CW         = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  req_op,
	input  wire logic signed [31:0]    req_value,
	output logic                       done_valid,
	input  wire logic                  done_ready,
	output smpq_result_t               done_result,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [DATA_WIDTH-1:0]      wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  wire logic [DATA_WIDTH-1:0] rd_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_PLACE = 3'd2;
	localparam logic [2:0] S_REM   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         idx_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [VALUE_W-1:0]    pend_value_q;
	logic [1:0]            pend_status_q;

	logic signed [63:0]    value_ext;
	logic [DATA_WIDTH-1:0] in_val;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [AW-1:0]         last_idx;
	logic                  gt;

	assign value_ext = 64'(req_value);
	assign in_val    = DATA_WIDTH'(value_ext);
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign last_idx  = AW'(count_q - CW'(1));
	assign gt        = $signed(val_q) > $signed(rd_data);

	assign done_valid              = (state_q == S_FIN);
	assign done_result.value_out   = pend_value_q;
	assign done_result.status      = pend_status_q;
	assign done_result.queue_empty = empty;
	assign done_result.fill_count  = FILL_W'(count_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && req_op == OP_INSERT && !full && !empty) begin
					rd_en   = 1'b1;
					rd_addr = last_idx;
				end else if (accept && req_op == OP_REMOVE && !empty) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = AW'(idx_q + AW'(1));
				if (gt) begin
					wr_data = rd_data;
					if (idx_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = AW'(idx_q - AW'(1));
					end
				end else begin
					wr_data = val_q;
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = val_q;
			end
			S_REM: begin
				if (idx_q != '0) begin
					wr_en   = 1'b1;
					wr_addr = AW'(idx_q - AW'(1));
					wr_data = rd_data;
				end
				if (idx_q != last_idx) begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_q + AW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_op == OP_INSERT) begin
							if (full) begin
								state_q <= S_FIN;
							end else if (empty) begin
								state_q <= S_PLACE;
							end else begin
								state_q <= S_INS;
							end
						end else begin
							if (empty) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_REM;
							end
						end
					end
				end
				S_INS: begin
					if (gt) begin
						if (idx_q == '0) begin
							state_q <= S_PLACE;
						end
					end else begin
						count_q <= CW'(count_q + CW'(1));
						state_q <= S_FIN;
					end
				end
				S_PLACE: begin
					count_q <= CW'(count_q + CW'(1));
					state_q <= S_FIN;
				end
				S_REM: begin
					if (idx_q == last_idx) begin
						count_q <= CW'(count_q - CW'(1));
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (done_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q        <= in_val;
					pend_value_q <= '0;
					if (req_op == OP_INSERT) begin
						idx_q         <= last_idx;
						pend_status_q <= full ? ST_FULL : ST_OK;
					end else begin
						idx_q         <= '0;
						pend_status_q <= empty ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_INS: begin
				if (gt && idx_q != '0) begin
					idx_q <= AW'(idx_q - AW'(1));
				end
			end
			S_REM: begin
				if (idx_q == '0) begin
					pend_value_q <= VALUE_W'(rd_data);
				end
				if (idx_q != last_idx) begin
					idx_q <= AW'(idx_q + AW'(1));
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/smpq_checker.sv
`default_nettype none
module smpq_checker
	import smpq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic signed [31:0] rsp_value_out,
	input wire logic [1:0]         rsp_status,
	input wire logic               rsp_queue_empty,
	input wire logic [4:0]         rsp_fill_count
);

	// stalled beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
			&& $stable(rsp_status) && $stable(rsp_fill_count))
		else $error("response beat changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_queue_empty == (rsp_fill_count == 5'd0 && CAPACITY < 32))
			|| CAPACITY >= 32)
		else $error("empty flag disagrees with fill count");

	a_remove_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_queue_empty && rsp_value_out == 32'sd0)
		else $error("remove from empty queue reported wrong");

	a_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |->
			!rsp_queue_empty && rsp_fill_count == 5'(CAPACITY) && rsp_value_out == 32'sd0)
		else $error("insert into full queue reported wrong");

endmodule

bind sorted_max_priority_queue_unit smpq_checker #(
	.CAPACITY (CAPACITY)
) u_smpq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_value_out   (rsp.value_out),
	.rsp_status      (rsp.status),
	.rsp_queue_empty (rsp.queue_empty),
	.rsp_fill_count  (rsp.fill_count)
);
`default_nettype wire
